>>> design/wcf_pkg.sv
// ----------------------------------------------------------------------------
// wcf_pkg
// Shared types and constants for the CRC-8 word framer and checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wcf_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_RX = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    logic       status;
    logic       last;
  } res_entry_t;

  // All results caused by one input item: a count of zero, one or two.
  typedef struct packed {
    logic [1:0] cnt;
    res_entry_t e0;
    res_entry_t e1;
  } res_pair_t;

endpackage

`default_nettype wire

>>> design/wcf_crc8.sv
// ----------------------------------------------------------------------------
// wcf_crc8
// CRC-8 of one 16-bit word, polynomial 0x31, initial 0xFF, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wcf_crc8 (
  input  wire logic [7:0] hi,
  input  wire logic [7:0] lo,
  output logic      [7:0] crc
);

  function automatic logic [7:0] crc_byte(input logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    for (int b = 0; b < 8; b++) begin
      if ((c & wcf_pkg::CRC_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ wcf_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  logic [7:0] mid;

  always_comb begin
    mid = crc_byte(wcf_pkg::CRC_INIT ^ hi);
    crc = crc_byte(mid ^ lo);
  end

endmodule

`default_nettype wire

>>> design/wcf_core.sv
// ----------------------------------------------------------------------------
// wcf_core
// Framing and checking state; turns one item into its group of results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wcf_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take,
  input  wire logic             kind,
  input  wire logic [7:0]       byte_in,
  input  wire logic             pass_through,
  input  wire logic             first,
  output wcf_pkg::res_pair_t    res
);

  logic       tx_phase_r, tx_phase_nxt;
  logic [7:0] tx_hold_r, tx_hold_nxt;
  logic [1:0] rx_phase_r, rx_phase_nxt;
  logic [7:0] rx_hold0_r, rx_hold0_nxt;
  logic [7:0] rx_hold1_r, rx_hold1_nxt;
  logic       rx_failed_r, rx_failed_nxt;

  logic       tx_ph;
  logic [1:0] rx_ph;
  logic       rx_fail;
  logic [7:0] crc_hi, crc_lo, crc;

  // One CRC unit serves both directions.
  assign crc_hi = (kind == wcf_pkg::KIND_RX) ? rx_hold0_r : tx_hold_r;
  assign crc_lo = (kind == wcf_pkg::KIND_RX) ? rx_hold1_r : byte_in;

  wcf_crc8 u_crc (
    .hi  (crc_hi),
    .lo  (crc_lo),
    .crc (crc)
  );

  always_comb begin
    tx_phase_nxt  = tx_phase_r;
    tx_hold_nxt   = tx_hold_r;
    rx_phase_nxt  = rx_phase_r;
    rx_hold0_nxt  = rx_hold0_r;
    rx_hold1_nxt  = rx_hold1_r;
    rx_failed_nxt = rx_failed_r;
    res           = '0;

    tx_ph   = first ? 1'b0 : tx_phase_r;
    rx_ph   = first ? 2'd0 : rx_phase_r;
    rx_fail = first ? 1'b0 : rx_failed_r;
    if (rx_ph == 2'd3) begin
      rx_ph = 2'd0;
    end

    if (kind == wcf_pkg::KIND_TX) begin
      tx_phase_nxt = tx_ph;
      if (pass_through) begin
        res.cnt = 2'd1;
        res.e0  = '{data: byte_in, status: wcf_pkg::STATUS_OK, last: 1'b1};
      end else if (!tx_ph) begin
        tx_hold_nxt  = byte_in;
        tx_phase_nxt = 1'b1;
        res.cnt      = 2'd1;
        res.e0       = '{data: byte_in, status: wcf_pkg::STATUS_OK, last: 1'b1};
      end else begin
        tx_phase_nxt = 1'b0;
        res.cnt      = 2'd2;
        res.e0       = '{data: byte_in, status: wcf_pkg::STATUS_OK, last: 1'b0};
        res.e1       = '{data: crc, status: wcf_pkg::STATUS_OK, last: 1'b1};
      end
    end else if (!rx_fail) begin
      // A message that already failed keeps all receive state until the next first.
      rx_failed_nxt = 1'b0;
      if (rx_ph != 2'd2) begin
        if (rx_ph[0]) begin
          rx_hold1_nxt = byte_in;
        end else begin
          rx_hold0_nxt = byte_in;
        end
        rx_phase_nxt = rx_ph + 2'd1;
      end else begin
        rx_phase_nxt = 2'd0;
        if (crc == byte_in) begin
          res.cnt = 2'd2;
          res.e0  = '{data: rx_hold0_r, status: wcf_pkg::STATUS_OK, last: 1'b0};
          res.e1  = '{data: rx_hold1_r, status: wcf_pkg::STATUS_OK, last: 1'b1};
        end else begin
          rx_failed_nxt = 1'b1;
          res.cnt       = 2'd1;
          res.e0        = '{data: 8'h00, status: wcf_pkg::STATUS_ERR, last: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_phase_r  <= 1'b0;
      rx_phase_r  <= 2'd0;
      rx_failed_r <= 1'b0;
    end else if (take) begin
      tx_phase_r  <= tx_phase_nxt;
      rx_phase_r  <= rx_phase_nxt;
      rx_failed_r <= rx_failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tx_hold_r  <= tx_hold_nxt;
      rx_hold0_r <= rx_hold0_nxt;
      rx_hold1_r <= rx_hold1_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/wcf_outbuf.sv
// ----------------------------------------------------------------------------
// wcf_outbuf
// Two-slot result register; loads a whole group, drains one a cycle while ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wcf_outbuf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire wcf_pkg::res_pair_t res,
  output logic                    can_load,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte_out,
  output logic                    out_status,
  output logic                    out_last
);

  logic [1:0]          cnt_r, cnt_nxt;
  wcf_pkg::res_entry_t slot0_r, slot0_nxt;
  wcf_pkg::res_entry_t slot1_r, slot1_nxt;
  logic                pop;

  assign out_valid    = (cnt_r != 2'd0);
  assign pop          = out_valid && out_ready;
  // A new group may enter once the last waiting result leaves in this cycle.
  assign can_load     = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_byte_out = slot0_r.data;
  assign out_status   = slot0_r.status;
  assign out_last     = slot0_r.last;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (load) begin
      cnt_nxt   = res.cnt;
      slot0_nxt = res.e0;
      slot1_nxt = res.e1;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

`default_nettype wire

>>> design/word_crc8_framer_checker.sv
// ----------------------------------------------------------------------------
// word_crc8_framer_checker
// CRC-8 (0x31) word framer for transmit bytes and checker for received bytes.
// ----------------------------------------------------------------------------
// An input transfer lands in an input register; from there combinational logic
// updates the framing state and writes all results of the item (none, one or
// two) into a two-slot output register, which drains one result per cycle
// while out_ready is high. Items that give at most one result flow at one per
// cycle while the output is not stalled; an item that gives two results (a
// transmit word's second byte plus its CRC, or a checked received word) fills
// both slots, so the next item is taken only as the second of them leaves. The
// first result reaches the port through the input and then the output register.
// The input register takes a new item while results still wait downstream.
`timescale 1ns / 1ps
`default_nettype none

module word_crc8_framer_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_byte_in,
  input  wire logic       in_pass_through,
  input  wire logic       in_first,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte_out,
  output logic            out_status,
  output logic            out_last
);

  logic               in_valid_r;
  logic               kind_r;
  logic [7:0]         byte_r;
  logic               pass_r;
  logic               first_r;
  logic               take;
  logic               can_load;
  wcf_pkg::res_pair_t res;

  assign take     = in_valid_r && can_load;
  assign in_ready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= in_kind;
      byte_r  <= in_byte_in;
      pass_r  <= in_pass_through;
      first_r <= in_first;
    end
  end

  wcf_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .kind         (kind_r),
    .byte_in      (byte_r),
    .pass_through (pass_r),
    .first        (first_r),
    .res          (res)
  );

  wcf_outbuf u_outbuf (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (take),
    .res          (res),
    .can_load     (can_load),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte_out (out_byte_out),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  // The input side stalls only while an item waits in the input register.
  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r)
    else $error("input stalled with an empty input register");

  // An item that causes results has its first one on the port in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res.cnt != 2'd0) |=> out_valid)
    else $error("results of an item did not appear");

  // An error result is always a lone zero byte that ends its group.
  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == wcf_pkg::STATUS_ERR) |-> (out_last && out_byte_out == 8'h00))
    else $error("malformed error result");

  // The second result of a group is ready right after the first is transferred.
  a_pair_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("second result of a group went missing");

endmodule

`default_nettype wire

>>> tb/wcf_result_checker.sv
// ----------------------------------------------------------------------------
// wcf_result_checker
// Watches both channels of the CRC-8 word framer and checker, predicts the
// results of every input transfer and compares them with the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wcf_tb_pkg;

  import wcf_pkg::*;

  // CRC-8 over one 16-bit word, high byte first, MSB first, no final XOR.
  function automatic logic [7:0] crc8_word(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] c;
    logic [7:0] pair [2];
    int         i;
    int         b;
    pair[0] = hi;
    pair[1] = lo;
    c = CRC_INIT;
    for (i = 0; i < 2; i++) begin
      c = c ^ pair[i];
      for (b = 0; b < 8; b++) begin
        if ((c & CRC_TOP) != 8'h00) begin
          c = (c << 1) ^ CRC_POLY;
        end else begin
          c = c << 1;
        end
      end
    end
    return c;
  endfunction

endpackage

module wcf_result_checker
  import wcf_pkg::*;
  import wcf_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_byte_in,
  input  logic       in_pass_through,
  input  logic       in_first,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte_out,
  input  logic       out_status,
  input  logic       out_last,
  output int         errors,
  output int         pending
);

  // Framing and checking state of the predictor.
  logic       tx_half;
  logic [7:0] tx_first_byte;
  logic [1:0] rx_count;
  logic [7:0] rx_bytes [2];
  logic       rx_dropping;

  res_entry_t pending_results[$];
  res_entry_t got;
  res_entry_t want;
  int         n_fail;

  initial begin
    n_fail = 0;
  end

  task automatic push_result(input logic [7:0] data, input logic status, input logic last);
    res_entry_t r;
    r.data   = data;
    r.status = status;
    r.last   = last;
    pending_results.push_back(r);
  endtask

  task automatic frame_or_check(input logic kind, input logic [7:0] b, input logic pass,
                                input logic first);
    if (kind == KIND_TX) begin
      if (first) begin
        tx_half = 1'b0;
      end
      if (pass) begin
        // Raw bytes do not disturb a word that is half sent.
        push_result(b, STATUS_OK, 1'b1);
      end else if (!tx_half) begin
        tx_first_byte = b;
        tx_half       = 1'b1;
        push_result(b, STATUS_OK, 1'b1);
      end else begin
        tx_half = 1'b0;
        push_result(b, STATUS_OK, 1'b0);
        push_result(crc8_word(tx_first_byte, b), STATUS_OK, 1'b1);
      end
    end else begin
      if (first) begin
        rx_count    = 2'd0;
        rx_dropping = 1'b0;
      end
      if (!rx_dropping) begin
        if (rx_count < 2'd2) begin
          rx_bytes[rx_count[0]] = b;
          rx_count = rx_count + 2'd1;
        end else begin
          rx_count = 2'd0;
          if (crc8_word(rx_bytes[0], rx_bytes[1]) == b) begin
            push_result(rx_bytes[0], STATUS_OK, 1'b0);
            push_result(rx_bytes[1], STATUS_OK, 1'b1);
          end else begin
            rx_dropping = 1'b1;
            push_result(8'h00, STATUS_ERR, 1'b1);
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tx_half       = 1'b0;
      tx_first_byte = 8'h00;
      rx_count      = 2'd0;
      rx_bytes[0]   = 8'h00;
      rx_bytes[1]   = 8'h00;
      rx_dropping   = 1'b0;
      pending_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        frame_or_check(in_kind, in_byte_in, in_pass_through, in_first);
      end
      if (out_valid && out_ready) begin
        got.data   = out_byte_out;
        got.status = out_status;
        got.last   = out_last;
        if (pending_results.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("%0t: unexpected result byte=%h status=%b last=%b", $realtime,
                     got.data, got.status, got.last);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.data !== want.data || got.status !== want.status ||
              got.last !== want.last) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: mismatch byte exp=%h got=%h status exp=%b got=%b last exp=%b got=%b",
                       $realtime, want.data, got.data, want.status, got.status,
                       want.last, got.last);
            end
          end
        end
      end
    end
    errors  <= n_fail;
    pending <= pending_results.size();
  end

endmodule

>>> tb/tb_word_crc8_framer_checker.sv
// ----------------------------------------------------------------------------
// tb_word_crc8_framer_checker
// Drives directed and random transmit and receive messages through the CRC-8
// word framer and checker under several idle and stall patterns, and reports
// the verdict from the result checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_word_crc8_framer_checker;

  import wcf_pkg::*;
  import wcf_tb_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_kind = KIND_TX;
  logic [7:0] in_byte_in = 8'h00;
  logic       in_pass_through = 1'b0;
  logic       in_first = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte_out;
  logic       out_status;
  logic       out_last;

  int errors;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int cycles = 0;

  always #10 clk = ~clk;

  word_crc8_framer_checker DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_byte_in      (in_byte_in),
    .in_pass_through (in_pass_through),
    .in_first        (in_first),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_out    (out_byte_out),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  wcf_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_byte_in      (in_byte_in),
    .in_pass_through (in_pass_through),
    .in_first        (in_first),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_out    (out_byte_out),
    .out_status      (out_status),
    .out_last        (out_last),
    .errors          (errors),
    .pending         (pending)
  );

  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL word_crc8_framer_checker");
      $finish;
    end
  end

  // Returns at the edge where the transfer happens, with valid still high.
  task automatic send_item(input logic kind, input logic [7:0] b, input logic pass,
                           input logic first);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_byte_in      <= b;
    in_pass_through <= pass;
    in_first        <= first;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sent++;
  endtask

  // The first wait lets the checker count the transfer of the last edge.
  task automatic drain_results();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending != 0);
  endtask

  task automatic send_rx_word(input logic [7:0] hi, input logic [7:0] lo, input logic first,
                              input logic corrupt);
    logic [7:0] crc;
    crc = crc8_word(hi, lo);
    if (corrupt) begin
      crc = crc ^ (8'h01 << $urandom_range(0, 7));
    end
    send_item(KIND_RX, hi, $urandom_range(0, 9) == 0, first);
    send_item(KIND_RX, lo, $urandom_range(0, 9) == 0, 1'b0);
    send_item(KIND_RX, crc, $urandom_range(0, 9) == 0, 1'b0);
  endtask

  task automatic send_tx_message();
    int n_addr;
    int n_data;
    int i;
    logic first;
    n_addr = $urandom_range(0, 2);
    n_data = $urandom_range(1, 6);
    // Now and then a message continues the alignment of the previous one.
    first = $urandom_range(0, 9) != 0;
    for (i = 0; i < n_addr; i++) begin
      send_item(KIND_TX, 8'($urandom), 1'b1, first);
      first = 1'b0;
    end
    for (i = 0; i < n_data; i++) begin
      send_item(KIND_TX, 8'($urandom), 1'b0, first);
      first = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        send_item(KIND_TX, 8'($urandom), 1'b1, 1'b0);
      end
    end
  endtask

  task automatic send_rx_message();
    int n_words;
    int i;
    n_words = $urandom_range(1, 4);
    for (i = 0; i < n_words; i++) begin
      send_rx_word(8'($urandom), 8'($urandom), i == 0, $urandom_range(0, 6) == 0);
      // A stray transmit byte inside a receive message must not disturb it.
      if ($urandom_range(0, 14) == 0) begin
        send_item(KIND_TX, 8'($urandom), 1'($urandom), 1'b0);
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      // A group cut short, left for the next first to clear.
      send_item(KIND_RX, 8'($urandom), 1'($urandom), 1'b0);
    end
  endtask

  task automatic send_noise();
    int n;
    int i;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      send_item(1'($urandom), 8'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    int phase;
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Transmit: a word, address bytes, a raw byte inside a word, a restart.
    send_item(KIND_TX, 8'hBE, 1'b0, 1'b1);
    send_item(KIND_TX, 8'hEF, 1'b0, 1'b0);
    send_item(KIND_TX, 8'h00, 1'b1, 1'b1);
    send_item(KIND_TX, 8'hFF, 1'b1, 1'b0);
    send_item(KIND_TX, 8'h12, 1'b0, 1'b0);
    send_item(KIND_TX, 8'hA5, 1'b1, 1'b0);
    send_item(KIND_TX, 8'h34, 1'b0, 1'b0);
    send_item(KIND_TX, 8'h55, 1'b0, 1'b0);
    send_item(KIND_TX, 8'hFF, 1'b0, 1'b1);
    send_item(KIND_TX, 8'h00, 1'b0, 1'b0);
    // Receive: good words, the raw flag ignored, a restart inside a group.
    send_item(KIND_RX, 8'hBE, 1'b0, 1'b1);
    send_item(KIND_RX, 8'hEF, 1'b0, 1'b0);
    send_item(KIND_RX, crc8_word(8'hBE, 8'hEF), 1'b0, 1'b0);
    send_item(KIND_RX, 8'h00, 1'b1, 1'b1);
    send_item(KIND_RX, 8'hFF, 1'b1, 1'b0);
    send_item(KIND_RX, crc8_word(8'h00, 8'hFF), 1'b1, 1'b0);
    send_item(KIND_RX, 8'h11, 1'b0, 1'b1);
    // A bad CRC, then bytes that are dropped until the next first.
    send_item(KIND_RX, 8'hBE, 1'b0, 1'b1);
    send_item(KIND_RX, 8'hEF, 1'b0, 1'b0);
    send_item(KIND_RX, crc8_word(8'hBE, 8'hEF) ^ 8'h01, 1'b0, 1'b0);
    send_item(KIND_RX, 8'h01, 1'b0, 1'b0);
    send_item(KIND_RX, 8'h02, 1'b0, 1'b0);
    send_item(KIND_TX, 8'h77, 1'b0, 1'b0);
    send_item(KIND_RX, 8'hFF, 1'b0, 1'b1);
    send_item(KIND_RX, 8'hFF, 1'b0, 1'b0);
    send_item(KIND_RX, crc8_word(8'hFF, 8'hFF), 1'b0, 1'b0);
    drain_results();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= (phase + 1) * (RANDOM_ITEMS / 8)) begin
        phase++;
        drain_results();
        case (phase % 4)
          0: begin
            idle_pct  = 0;
            stall_pct = 0;
          end
          1: begin
            idle_pct  = 69;
            stall_pct = 0;
          end
          2: begin
            idle_pct  = 0;
            stall_pct = 69;
          end
          default: begin
            idle_pct  = 12;
            stall_pct = 12;
          end
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_tx_message();
      end else if (pick < 82) begin
        send_rx_message();
      end else begin
        send_noise();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS word_crc8_framer_checker");
    end else begin
      $display("FAIL word_crc8_framer_checker");
    end
    $finish;
  end

endmodule
